// ===== design/audio_frame_ring_buffer_macros.svh =====
// assertion helpers for the frame ring buffer
`ifndef AUDIO_FRAME_RING_BUFFER_MACROS_SVH
`define AUDIO_FRAME_RING_BUFFER_MACROS_SVH

`ifndef SYNTH

`define AFRB_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("afrb assertion failed");

`define AFRB_ASSERT_NEVER(label, clk, rst, cond) \
   `AFRB_ASSERT(label, clk, rst, !(cond))

`else

`define AFRB_ASSERT(label, clk, rst, prop)

`define AFRB_ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

// ===== design/afrb_pkg.sv =====
`default_nettype none

package afrb_pkg;

   localparam int FRAME_SIZE = 256;
   localparam int RING_SLOTS = 4;
   localparam int BYTE_W     = 8;
   localparam int SAMPLE_W   = 2 * BYTE_W;

   localparam int POS_W      = $clog2(FRAME_SIZE);
   localparam int SLOT_W     = $clog2(RING_SLOTS);
   localparam int STORE_SIZE = RING_SLOTS * FRAME_SIZE;
   localparam int ADDR_W     = $clog2(STORE_SIZE);

   typedef logic [POS_W-1:0]  pos_type;
   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [ADDR_W-1:0] addr_type;

   typedef enum logic {
      CMD_PUSH = 1'b0,
      CMD_READ = 1'b1
   } cmd_type;

   typedef struct packed {
      logic sample_valid;
      logic last_of_frame;
      logic frame_committed;
      logic frame_dropped;
   } rsp_flags_type;

   localparam pos_type  POS_LAST  = POS_W'(FRAME_SIZE - 1);
   localparam slot_type SLOT_LAST = SLOT_W'(RING_SLOTS - 1);

   function automatic slot_type next_slot(input slot_type slot);
      return (slot == SLOT_LAST) ? '0 : slot + 1'b1;
   endfunction

   function automatic addr_type slot_addr(input slot_type slot, input pos_type pos);
      return ADDR_W'(slot) * ADDR_W'(FRAME_SIZE) + ADDR_W'(pos);
   endfunction

endpackage

`default_nettype wire

// ===== design/audio_frame_ring_buffer.sv =====
// frame ring buffer for left-channel audio samples
// command channel: an item is taken when start is high and busy is low; busy
// stays low, so one command can be taken in every cycle
// req_cmd = push: the little-endian left sample {req_left_high, req_left_low}
// is written into the slot being filled; the last sample of a frame commits it
// to the ring, or drops it when the ring already holds all but one slot
// req_cmd = read: the next sample of the oldest committed frame is returned,
// rsp_last_of_frame marks its final sample and frees the slot; a read on an
// empty ring gives a result with every field zero
// every command gives exactly one result in the cycle after the transfer, shown
// for a single cycle under rsp_strobe; the receiver cannot stall it
// throughput is one command per cycle: the sample store is a single memory
// with one write and one registered read port, and a command uses one of them
// reset clears the slot and position counters and the result flags; the
// sample store itself is not cleared and needs no clearing pass
`default_nettype none

`include "audio_frame_ring_buffer_macros.svh"

module audio_frame_ring_buffer (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire afrb_pkg::cmd_type                   req_cmd,
   input  wire logic [7:0]                          req_left_low,
   input  wire logic [7:0]                          req_left_high,
   output logic                                     rsp_strobe,
   output logic signed [afrb_pkg::SAMPLE_W-1:0]     rsp_sample,
   output logic                                     rsp_sample_valid,
   output logic                                     rsp_last_of_frame,
   output logic                                     rsp_frame_committed,
   output logic                                     rsp_frame_dropped
);

   import afrb_pkg::*;

   slot_type      wr_slot_ff, wr_slot_in;
   slot_type      rd_slot_ff, rd_slot_in;
   pos_type       fill_pos_ff, fill_pos_in;
   pos_type       rd_pos_ff, rd_pos_in;
   logic          strobe_ff, strobe_in;
   rsp_flags_type flags_ff, flags_in;

   logic                accept;
   logic                ring_empty;
   logic                do_push;
   logic                do_read;
   logic                ring_full;
   logic [SAMPLE_W-1:0] push_sample;
   logic [SAMPLE_W-1:0] ram_q;

   assign busy        = 1'b0;
   assign accept      = start && !busy;
   assign ring_empty  = (rd_slot_ff == wr_slot_ff);
   assign do_push     = accept && (req_cmd == CMD_PUSH);
   assign do_read     = accept && (req_cmd == CMD_READ) && !ring_empty;
   assign ring_full   = (next_slot(wr_slot_ff) == rd_slot_ff);
   assign push_sample = {req_left_high, req_left_low};

   afrb_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (STORE_SIZE)
   ) u_store (
      .clock   (clock),
      .wr_en   (do_push),
      .wr_addr (slot_addr(wr_slot_ff, fill_pos_ff)),
      .wr_data (push_sample),
      .rd_en   (do_read),
      .rd_addr (slot_addr(rd_slot_ff, rd_pos_ff)),
      .rd_data (ram_q)
   );

   always_comb begin
      wr_slot_in  = wr_slot_ff;
      rd_slot_in  = rd_slot_ff;
      fill_pos_in = fill_pos_ff;
      rd_pos_in   = rd_pos_ff;
      strobe_in   = accept;
      flags_in    = '0;

      if (do_push) begin
         if (fill_pos_ff == POS_LAST) begin
            fill_pos_in = '0;
            if (ring_full) begin
               flags_in.frame_dropped = 1'b1;
            end else begin
               wr_slot_in               = next_slot(wr_slot_ff);
               flags_in.frame_committed = 1'b1;
            end
         end else begin
            fill_pos_in = fill_pos_ff + 1'b1;
         end
      end

      if (do_read) begin
         flags_in.sample_valid = 1'b1;
         if (rd_pos_ff == POS_LAST) begin
            // final sample: free the slot
            rd_pos_in              = '0;
            rd_slot_in             = next_slot(rd_slot_ff);
            flags_in.last_of_frame = 1'b1;
         end else begin
            rd_pos_in = rd_pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_slot_ff  <= '0;
         rd_slot_ff  <= '0;
         fill_pos_ff <= '0;
         rd_pos_ff   <= '0;
         strobe_ff   <= 1'b0;
         flags_ff    <= '0;
      end else begin
         wr_slot_ff  <= wr_slot_in;
         rd_slot_ff  <= rd_slot_in;
         fill_pos_ff <= fill_pos_in;
         rd_pos_ff   <= rd_pos_in;
         strobe_ff   <= strobe_in;
         flags_ff    <= flags_in;
      end
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_sample          = flags_ff.sample_valid ? ram_q : '0;
   assign rsp_sample_valid    = flags_ff.sample_valid;
   assign rsp_last_of_frame   = flags_ff.last_of_frame;
   assign rsp_frame_committed = flags_ff.frame_committed;
   assign rsp_frame_dropped   = flags_ff.frame_dropped;

   // every transfer gives one result in the next cycle
   `AFRB_ASSERT(a_result_follows, clock, reset, accept |=> rsp_strobe)

   `AFRB_ASSERT(a_flags_need_strobe, clock, reset,
      (rsp_sample_valid || rsp_frame_committed || rsp_frame_dropped) |-> rsp_strobe)

   // frame completion always restarts filling at the slot start
   `AFRB_ASSERT(a_fill_restart, clock, reset,
      (rsp_frame_committed || rsp_frame_dropped) |-> (fill_pos_ff == '0))

   `AFRB_ASSERT(a_read_advances, clock, reset,
      (rsp_sample_valid && !rsp_last_of_frame) |-> (rd_pos_ff != '0))

   `AFRB_ASSERT_NEVER(a_last_without_valid, clock, reset,
      rsp_last_of_frame && !rsp_sample_valid)

endmodule

`default_nettype wire

// ===== design/afrb_ram.sv =====
`default_nettype none

module afrb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== test/tb_audio_frame_ring_buffer.sv =====
`timescale 1ns / 1ps

module tb_audio_frame_ring_buffer;
   import afrb_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int ITEM_TARGET = 750;
   localparam int TAIL_CYCLES = 8;

   typedef struct {
      cmd_type    cmd;
      logic [7:0] lo;
      logic [7:0] hi;
      int         gap;
      bit         drain;
   } ring_cmd_type;

   typedef struct {
      logic [SAMPLE_W-1:0] sample;
      logic                valid;
      logic                last;
      logic                committed;
      logic                dropped;
   } ring_result_type;

   typedef enum {RUN_PUSH, RUN_READ, RUN_MIXED} run_kind_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   cmd_type    req_cmd = CMD_PUSH;
   logic [7:0] req_left_low = 8'h00;
   logic [7:0] req_left_high = 8'h00;

   logic                       busy;
   logic                       rsp_strobe;
   logic signed [SAMPLE_W-1:0] rsp_sample;
   logic                       rsp_sample_valid;
   logic                       rsp_last_of_frame;
   logic                       rsp_frame_committed;
   logic                       rsp_frame_dropped;

   audio_frame_ring_buffer dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_cmd             (req_cmd),
      .req_left_low        (req_left_low),
      .req_left_high       (req_left_high),
      .rsp_strobe          (rsp_strobe),
      .rsp_sample          (rsp_sample),
      .rsp_sample_valid    (rsp_sample_valid),
      .rsp_last_of_frame   (rsp_last_of_frame),
      .rsp_frame_committed (rsp_frame_committed),
      .rsp_frame_dropped   (rsp_frame_dropped)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   ring_cmd_type    pending_cmds[$];
   ring_result_type predicted_results[$];
   int              issued;
   int              received;
   int              wait_left;
   int              error_count = 0;

   // shadow of the ring state
   logic [SAMPLE_W-1:0] sample_mem [STORE_SIZE];
   int                  wr_slot = 0;
   int                  rd_slot = 0;
   int                  fill_pos = 0;
   int                  rd_pos = 0;

   function automatic int slot_after(int s);
      return (s == RING_SLOTS - 1) ? 0 : s + 1;
   endfunction

   task automatic ring_predict(cmd_type c, logic [7:0] lo, logic [7:0] hi);
      ring_result_type r;
      int              nxt;
      r = '{sample: '0, valid: 1'b0, last: 1'b0, committed: 1'b0, dropped: 1'b0};
      if (c == CMD_PUSH) begin
         sample_mem[wr_slot * FRAME_SIZE + fill_pos] = {hi, lo};
         if (fill_pos == FRAME_SIZE - 1) begin
            fill_pos = 0;
            nxt = slot_after(wr_slot);
            // a full ring keeps one slot free, so the frame is lost
            if (nxt != rd_slot) begin
               wr_slot = nxt;
               r.committed = 1'b1;
            end else begin
               r.dropped = 1'b1;
            end
         end else begin
            fill_pos++;
         end
      end else if (rd_slot != wr_slot) begin
         r.sample = sample_mem[rd_slot * FRAME_SIZE + rd_pos];
         r.valid  = 1'b1;
         if (rd_pos == FRAME_SIZE - 1) begin
            rd_pos  = 0;
            r.last  = 1'b1;
            rd_slot = slot_after(rd_slot);
         end else begin
            rd_pos++;
         end
      end
      predicted_results.push_back(r);
   endtask

   function automatic void flag_error(string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("mismatch at %0t: %s", $realtime, msg);
      end
   endfunction

   function automatic void check_field(string name, logic [SAMPLE_W-1:0] got,
                                       logic [SAMPLE_W-1:0] want);
      if (got !== want) begin
         flag_error($sformatf("%s expected %h got %h", name, want, got));
      end
   endfunction

   // driver: one command per transfer, gap counted before each one
   always @(posedge clock) begin : drive_proc
      int           left;
      bit           fired;
      bit           go;
      ring_cmd_type item;
      left  = wait_left;
      fired = start && !busy;
      go    = 1'b0;
      if (reset) begin
         start     <= 1'b0;
         wait_left <= -1;
         issued    <= 0;
      end else begin
         if (fired) begin
            ring_predict(req_cmd, req_left_low, req_left_high);
            issued <= issued + 1;
         end
         if ((!start || fired) && pending_cmds.size() != 0) begin
            if (left < 0) begin
               left = pending_cmds[0].gap;
            end
            if (left > 0) begin
               left--;
            end else if (!pending_cmds[0].drain || (issued == received && !fired)) begin
               go = 1'b1;
            end
         end
         if (go) begin
            item = pending_cmds.pop_front();
            req_cmd       <= item.cmd;
            req_left_low  <= item.lo;
            req_left_high <= item.hi;
            start         <= 1'b1;
            wait_left     <= -1;
         end else begin
            wait_left <= left;
            if (fired) begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor_proc
      ring_result_type want;
      if (reset) begin
         received <= 0;
      end else if (rsp_strobe) begin
         received <= received + 1;
         if (predicted_results.size() == 0) begin
            flag_error("result with no command outstanding");
         end else begin
            want = predicted_results.pop_front();
            check_field("sample", rsp_sample, want.sample);
            check_field("sample_valid", rsp_sample_valid, want.valid);
            check_field("last_of_frame", rsp_last_of_frame, want.last);
            check_field("frame_committed", rsp_frame_committed, want.committed);
            check_field("frame_dropped", rsp_frame_dropped, want.dropped);
         end
      end
   end

   task automatic queue_cmd(cmd_type c, logic [7:0] lo, logic [7:0] hi, int gap, bit drain);
      ring_cmd_type it;
      it.cmd   = c;
      it.lo    = lo;
      it.hi    = hi;
      it.gap   = gap;
      it.drain = drain;
      pending_cmds.push_back(it);
   endtask

   task automatic queue_run(run_kind_type kind, int len, bit drain_first);
      bit      calm;
      cmd_type c;
      calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
         case (kind)
            RUN_PUSH: c = CMD_PUSH;
            RUN_READ: c = CMD_READ;
            default:  c = cmd_type'($urandom_range(0, 1));
         endcase
         queue_cmd(c, 8'($urandom), 8'($urandom), calm ? 0 : $urandom_range(0, 14),
                   drain_first && i == 0);
      end
   endtask

   initial begin : stimulus
      int pick;
      int room;
      bit drain_next;
      drain_next = 1'b0;

      // empty ring, sample extremes, reads while the first frame is still filling
      queue_cmd(CMD_READ, 8'hFF, 8'hFF, 0, 1'b0);
      queue_cmd(CMD_READ, 8'h00, 8'h00, 3, 1'b0);
      queue_cmd(CMD_PUSH, 8'h00, 8'h00, 0, 1'b0);
      queue_cmd(CMD_PUSH, 8'hFF, 8'hFF, 0, 1'b0);
      queue_cmd(CMD_PUSH, 8'h00, 8'h80, 0, 1'b0);
      queue_cmd(CMD_PUSH, 8'hFF, 8'h7F, 2, 1'b0);
      queue_cmd(CMD_PUSH, 8'h01, 8'h00, 0, 1'b0);
      queue_cmd(CMD_PUSH, 8'h00, 8'h01, 0, 1'b0);
      queue_cmd(CMD_PUSH, 8'h80, 8'hFF, 5, 1'b0);
      queue_cmd(CMD_READ, 8'h5A, 8'hA5, 0, 1'b0);
      queue_cmd(CMD_PUSH, 8'hAA, 8'h55, 0, 1'b0);
      queue_cmd(CMD_PUSH, 8'h55, 8'hAA, 1, 1'b0);
      queue_cmd(CMD_READ, 8'h00, 8'hFF, 0, 1'b0);

      // complete and commit the first frame, then start on the next
      queue_run(RUN_PUSH, FRAME_SIZE + $urandom_range(0, 30), 1'b0);
      // drain a whole frame and run on into an empty ring
      queue_run(RUN_READ, FRAME_SIZE + $urandom_range(0, 20), 1'b1);

      while (pending_cmds.size() < ITEM_TARGET) begin
         room = ITEM_TARGET - pending_cmds.size();
         pick = $urandom_range(0, 9);
         if (pick <= 3) begin
            queue_run(RUN_PUSH, $urandom_range(1, (room < 300) ? room : 300), drain_next);
            drain_next = 1'b0;
         end else if (pick <= 6) begin
            queue_run(RUN_READ, $urandom_range(1, (room < 300) ? room : 300), drain_next);
            drain_next = 1'b0;
         end else if (pick <= 8) begin
            queue_run(RUN_MIXED, $urandom_range(1, (room < 40) ? room : 40), drain_next);
            drain_next = 1'b0;
         end else begin
            drain_next = 1'b1;
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() != 0 || start || issued != received) begin
         @(negedge clock);
      end
      repeat (TAIL_CYCLES) @(negedge clock);

      if (predicted_results.size() != 0) begin
         flag_error($sformatf("%0d results never arrived", predicted_results.size()));
      end
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

endmodule
